>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds in every cycle outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("assertion failed");

`endif

>>> rtl/ttpp_pkg.sv
`default_nettype none

package ttpp_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned TIME_WIDTH_DEF  = 16;

  localparam int unsigned CNT_W     = 32;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned OFFSET_W  = 16;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned ETIME_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_SEND   = 2'd2,
    MODE_TOGGLE = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_LEVEL   = 2'd0,
    CFG_IDLE_TIMEOUT = 2'd1,
    CFG_REPEAT_OFS   = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  localparam logic                 IDLE_LEVEL_RST   = 1'b1;
  localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 16'd1000;
  localparam logic [OFFSET_W-1:0]  REPEAT_OFS_RST   = 16'd0;

  // Status fields carried in the result.
  typedef struct packed {
    logic send_pending;
    logic busy_res;
    logic line_level;
  } status_t;

  // Table write request toward the storage block.
  typedef struct packed {
    logic            en;
    logic [31:0]     addr;
    logic [31:0]     data;
  } tbl_wr_t;

endpackage

`default_nettype wire

>>> rtl/ttpp_table.sv
`default_nettype none

module ttpp_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned TW    = 16
) (
  input  wire logic              clk_i,
  input  wire ttpp_pkg::tbl_wr_t wr_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [TW-1:0]     rd_data_o
);
  import ttpp_pkg::*;

  logic [TW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_addr;
  logic [TW-1:0] wr_data;
  logic [TW-1:0] rd_data_q;

  assign wr_addr = wr_i.addr[AW-1:0];
  assign wr_data = wr_i.data[TW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Write-first on an address match so a read of the address being written returns the new data.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_addr == rd_addr_i)) begin
      rd_data_q <= wr_data;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/timed_toggle_pulse_player_core.sv
// Table-driven pulse train player.
// Input stream (s_axis_*): one request per beat; tuser carries the mode
// (tick, table write, send request, manual toggle), tdata the table index
// and toggle time. Every request yields exactly one status beat on the
// output stream (m_axis_*): line level, busy, send pending.
// Path: a request passes the input register, then the result register,
// whose output is the status beat. Throughput: one request per cycle while
// m_axis_tready does not stall the status beat; the per-request work is a
// compare, an add and a registered table read whose address is the next
// entry pointer, prefetched every cycle.
// Config port: cfg_we_i writes register cfg_idx_i with cfg_wdata_i at once;
// writes belong to idle periods.
// Reset: counter, pointer, pass and flags clear, the line drives 0, the
// config registers take their defaults; the table keeps no defined content.
// A stalled m_axis_tready holds the status beat; one more request can sit
// in the input register, after which s_axis_tready drops.
`default_nettype none
`include "assert_macros.svh"

module timed_toggle_pulse_player_core #(
  parameter int unsigned TABLE_DEPTH = ttpp_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH  = ttpp_pkg::TIME_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [5:0] entry_index, [21:6] entry_time, zero pad
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] line_level, [1] busy_res, [2] send_pending
  input  wire logic        cfg_we_i,
  input  wire logic [ttpp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ttpp_pkg::CFG_DAT_W-1:0] cfg_wdata_i
);
  import ttpp_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW = CNT_W + 2;

  // config registers
  logic                 idle_level_q;
  logic [TIMEOUT_W-1:0] idle_timeout_q;
  logic [OFFSET_W-1:0]  repeat_ofs_q;

  // input register
  logic               in_valid_q;
  mode_e              in_mode_q;
  logic [IDX_W-1:0]   in_idx_q;
  logic [ETIME_W-1:0] in_time_q;

  // result register
  logic    out_valid_q;
  status_t out_q;

  // player state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]    ptr_q, ptr_d;
  logic             pass_q, pass_d;
  logic             sending_q, sending_d;
  logic             pending_q, pending_d;
  logic             line_q, line_d;

  logic             adv;
  logic [CNT_W-1:0] cnt_inc;
  logic             ptr_end;
  logic [TIME_WIDTH-1:0] rd_entry;
  logic [TIME_WIDTH-1:0] entry;
  logic [DW-1:0]    due;
  logic [AW-1:0]    rd_addr;
  logic [31:0]      idx_ext;
  logic [31:0]      time_ext;
  tbl_wr_t          tbl_wr;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_level_q   <= IDLE_LEVEL_RST;
      idle_timeout_q <= IDLE_TIMEOUT_RST;
      repeat_ofs_q   <= REPEAT_OFS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IDLE_LEVEL:   idle_level_q   <= cfg_wdata_i[0];
        CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_wdata_i;
        CFG_REPEAT_OFS:   repeat_ofs_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode_q <= mode_e'(s_axis_tuser);
      in_idx_q  <= s_axis_tdata[IDX_W-1:0];
      in_time_q <= s_axis_tdata[IDX_W+ETIME_W-1:IDX_W];
    end
  end

  // table entry at the current pointer; past the end reads as frame end
  assign ptr_end = (ptr_q == PW'(TABLE_DEPTH));
  assign entry   = ptr_end ? '0 : rd_entry;
  assign cnt_inc = cnt_q + 1'b1;
  assign due     = DW'(entry) + (pass_q ? DW'(repeat_ofs_q) : '0);

  always_comb begin
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    pass_d    = pass_q;
    sending_d = sending_q;
    pending_d = pending_q;
    line_d    = line_q;
    unique case (in_mode_q)
      MODE_TICK: begin
        cnt_d = cnt_inc;
        if (!sending_q) begin
          // timeout restore is checked before a pending send starts
          if (cnt_inc == CNT_W'(idle_timeout_q) && line_q != idle_level_q) begin
            line_d = ~line_q;
          end
          if (pending_q) begin
            ptr_d     = '0;
            cnt_d     = '0;
            pending_d = 1'b0;
            sending_d = 1'b1;
          end
        end else if (entry == '0) begin
          if (pass_q) begin
            sending_d = 1'b0;
            pass_d    = 1'b0;
          end else begin
            ptr_d  = '0;
            pass_d = 1'b1;
          end
        end else if ({2'b00, cnt_inc} >= due) begin
          line_d = ~line_q;
          ptr_d  = ptr_q + 1'b1;
        end
      end
      MODE_WRITE:  ;
      MODE_SEND:   pending_d = 1'b1;
      MODE_TOGGLE: line_d = ~line_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      pass_q      <= 1'b0;
      sending_q   <= 1'b0;
      pending_q   <= 1'b0;
      line_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        cnt_q     <= cnt_d;
        ptr_q     <= ptr_d;
        pass_q    <= pass_d;
        sending_q <= sending_d;
        pending_q <= pending_d;
        line_q    <= line_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.line_level   <= line_d;
      out_q.busy_res     <= sending_d;
      out_q.send_pending <= pending_d;
    end
  end

  // table write path and prefetch of the entry at the next pointer
  assign idx_ext  = 32'(in_idx_q);
  assign time_ext = 32'(in_time_q);

  always_comb begin
    tbl_wr.en   = adv && (in_mode_q == MODE_WRITE) && (idx_ext < TABLE_DEPTH);
    tbl_wr.addr = idx_ext;
    tbl_wr.data = '0;
    tbl_wr.data[TIME_WIDTH-1:0] = time_ext[TIME_WIDTH-1:0];
  end

  always_comb begin
    logic [PW-1:0] ptr_nx;
    ptr_nx  = adv ? ptr_d : ptr_q;
    rd_addr = (ptr_nx == PW'(TABLE_DEPTH)) ? '0 : ptr_nx[AW-1:0];
  end

  ttpp_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .TW    (TIME_WIDTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.send_pending, out_q.busy_res, out_q.line_level};

  `ASSERT_ALWAYS(a_ptr_in_range, clk_i, rst_ni, ptr_q <= PW'(TABLE_DEPTH))
  `ASSERT_ALWAYS(a_pass_only_sending, clk_i, rst_ni, sending_q || !pass_q)
  `ASSERT_IMPL(a_adv_gives_result, clk_i, rst_ni, adv |=> m_axis_tvalid)

endmodule

`default_nettype wire

>>> verif/tb_top.sv
module tb_top;
  import ttpp_pkg::*;

  localparam int unsigned DEPTH          = TABLE_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned MAX_REPORTS    = 10;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata  = '0;  // [5:0] entry_index, [21:6] entry_time, zero pad
  logic [1:0]           s_axis_tuser  = '0;  // [1:0] mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // [0] line_level, [1] busy_res, [2] send_pending
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i   = '0;

  timed_toggle_pulse_player_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Player state as the predictor sees it.
  logic [ETIME_W-1:0]   toggle_times [DEPTH];
  logic [CNT_W-1:0]     tick_cnt      = '0;
  logic [6:0]           play_ptr      = '0;
  logic                 second_pass   = 1'b0;
  logic                 playing       = 1'b0;
  logic                 start_waiting = 1'b0;
  logic                 line_model    = 1'b0;
  logic                 idle_lvl      = IDLE_LEVEL_RST;
  logic [TIMEOUT_W-1:0] idle_tmo      = IDLE_TIMEOUT_RST;
  logic [OFFSET_W-1:0]  pass2_ofs     = REPEAT_OFS_RST;

  status_t     status_due_q [$];
  int          frame_len        = 0;  // index of the zero that ends the loaded frame (DEPTH if none)
  int unsigned items_sent       = 0;
  int unsigned mode_count [4]   = '{default: 0};
  int unsigned frames_started   = 0;
  int unsigned idle_restores    = 0;
  int unsigned beats_checked    = 0;
  int unsigned err_count        = 0;
  int unsigned burst_left       = 0;
  bit          bus_offered      = 1'b0;
  bit          no_gaps          = 1'b0;
  int unsigned hold_ticket      = 0;
  int unsigned hold_seen        = 0;
  int unsigned hold_left        = 0;
  int unsigned run_left         = 0;
  int unsigned stall_left       = 0;
  int unsigned quiet_cycles     = 0;
  status_t     st_exp;
  status_t     st_got;

  function automatic status_t player_step(mode_e m, logic [5:0] idx, logic [15:0] t);
    logic [ETIME_W-1:0]  cur;
    logic [OFFSET_W:0]   due;
    status_t             st;
    case (m)
      MODE_TICK: begin
        tick_cnt = tick_cnt + 1'b1;
        if (!playing) begin
          // timeout restore is checked before a waiting start
          if (tick_cnt == CNT_W'(idle_tmo) && line_model != idle_lvl) begin
            line_model = ~line_model;
            idle_restores++;
          end
          if (start_waiting) begin
            play_ptr      = '0;
            tick_cnt      = '0;
            start_waiting = 1'b0;
            playing       = 1'b1;
            frames_started++;
          end
        end else begin
          cur = (play_ptr < DEPTH) ? toggle_times[play_ptr[5:0]] : '0;
          if (cur == '0) begin
            if (second_pass) begin
              playing     = 1'b0;
              second_pass = 1'b0;
            end else begin
              play_ptr    = '0;
              second_pass = 1'b1;
            end
          end else begin
            due = {1'b0, cur} + (second_pass ? {1'b0, pass2_ofs} : '0);
            if (tick_cnt >= CNT_W'(due)) begin
              line_model = ~line_model;
              play_ptr   = play_ptr + 1'b1;
            end
          end
        end
      end
      MODE_WRITE:  toggle_times[idx] = t;
      MODE_SEND:   start_waiting = 1'b1;
      MODE_TOGGLE: line_model = ~line_model;
    endcase
    st.line_level   = line_model;
    st.busy_res     = playing;
    st.send_pending = start_waiting;
    return st;
  endfunction

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Status beat checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      st_got = status_t'(m_axis_tdata[2:0]);
      if (status_due_q.size() == 0) begin
        note_error($sformatf("unexpected status beat %b", m_axis_tdata));
      end else begin
        st_exp = status_due_q.pop_front();
        beats_checked++;
        if (st_got.line_level !== st_exp.line_level || st_got.busy_res !== st_exp.busy_res ||
            st_got.send_pending !== st_exp.send_pending || m_axis_tdata[7:3] !== '0) begin
          note_error($sformatf(
            "beat %0d: line exp %b got %b, busy exp %b got %b, pending exp %b got %b, pad %b",
            beats_checked, st_exp.line_level, st_got.line_level, st_exp.busy_res,
            st_got.busy_res, st_exp.send_pending, st_got.send_pending, m_axis_tdata[7:3]));
        end
      end
    end
  end

  // Receiver stalls: random runs and stalls, plus a long hold on request.
  always @(posedge clk_i) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (run_left == 0 && stall_left == 0) begin
      run_left   = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
      stall_left = $urandom_range(0, 6);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      m_axis_tready <= 1'b1;
    end else begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timed_toggle_pulse_player_core test failed");
      $finish;
    end
  end

  task automatic send_item(mode_e m, logic [5:0] idx, logic [15:0] t);
    if (burst_left == 0 && !no_gaps) begin
      if (bus_offered) s_axis_tvalid <= 1'b0;
      bus_offered = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {2'b00, t, idx};
    bus_offered = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    status_due_q.push_back(player_step(m, idx, t));
    if (burst_left > 0) burst_left--;
    items_sent++;
    mode_count[m]++;
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 6'($urandom), 16'($urandom));
  endtask

  task automatic send_toggle();
    send_item(MODE_TOGGLE, 6'($urandom), 16'($urandom));
  endtask

  task automatic send_request();
    send_item(MODE_SEND, 6'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    if (bus_offered) s_axis_tvalid <= 1'b0;
    bus_offered = 1'b0;
    do @(posedge clk_i); while (status_due_q.size() != 0);
  endtask

  task automatic set_registers(logic lvl, logic [15:0] tmo, logic [15:0] ofs);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IDLE_LEVEL;
    cfg_wdata_i <= {15'd0, lvl};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_IDLE_TIMEOUT;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_REPEAT_OFS;
    cfg_wdata_i <= ofs;
    @(posedge clk_i);
    // unused index must be ignored
    cfg_idx_i   <= CFG_UNUSED;
    cfg_wdata_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    idle_lvl  = lvl;
    idle_tmo  = tmo;
    pass2_ofs = ofs;
  endtask

  // Keeps entries before the frame end short and nonzero and the end entry zero, so frames stay bounded.
  function automatic logic [15:0] safe_time(logic [5:0] idx);
    if (idx < frame_len) return 16'($urandom_range(1, 40));
    if (idx == frame_len) return '0;
    return 16'($urandom);
  endfunction

  task automatic send_noise(bit allow_send);
    int unsigned pick;
    logic [5:0]  idx;
    pick = $urandom_range(0, 99);
    idx  = 6'($urandom_range(0, DEPTH - 1));
    if (allow_send && pick < 10) send_request();
    else if (pick < 55) send_toggle();
    else send_item(MODE_WRITE, idx, safe_time(idx));
  endtask

  task automatic play_out(int unsigned noise_pct);
    int unsigned guard;
    guard = 0;
    while ((playing || start_waiting) && guard < 200000) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise(1'b1);
      send_tick();
      guard++;
    end
  endtask

  task automatic idle_ticks(int unsigned n, int unsigned toggle_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < toggle_pct) send_toggle();
      else send_tick();
    end
  endtask

  task automatic load_frame(int unsigned n, int unsigned max_step);
    logic [15:0] t;
    t = 16'($urandom_range(1, 6));
    for (int unsigned i = 0; i < n; i++) begin
      send_item(MODE_WRITE, 6'(i), t);
      t = t + 16'($urandom_range(0, max_step));
      if ($urandom_range(0, 7) == 0) t = 16'($urandom_range(1, 30));
    end
    if (n < DEPTH) send_item(MODE_WRITE, 6'(n), '0);
    frame_len = n;
  endtask

  // Every entry gets written so no read ever hits an unwritten slot.
  task automatic test_table_fill();
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (i == 0) send_item(MODE_WRITE, 6'(i), '0);
      else if (i == DEPTH - 1) send_item(MODE_WRITE, 6'(i), 16'hFFFF);
      else send_item(MODE_WRITE, 6'(i), 16'($urandom));
    end
    frame_len = 0;
  endtask

  // Line comes out of reset low, away from the default idle level.
  task automatic test_reset_timeout();
    while (tick_cnt < 32'(IDLE_TIMEOUT_RST) + 3) send_tick();
  endtask

  task automatic test_empty_frame();
    set_registers(1'b0, 16'd5, 16'hFFFF);
    send_request();
    play_out(0);
    idle_ticks(8, 50);
  endtask

  task automatic test_short_frame();
    set_registers(1'b1, 16'd200, 16'd2);
    send_item(MODE_WRITE, 6'd0, 16'd4);
    send_item(MODE_WRITE, 6'd1, 16'd4);
    send_item(MODE_WRITE, 6'd2, 16'd9);
    send_item(MODE_WRITE, 6'd3, 16'd0);
    frame_len = 3;
    send_request();
    send_tick();
    send_tick();
    send_request();  // waits until the frame in flight is done
    send_toggle();
    send_item(MODE_WRITE, 6'd2, 16'd7);
    play_out(0);
  endtask

  task automatic test_timeout_then_start();
    set_registers(1'b1, 16'(tick_cnt + 32'd3), 16'd1);
    if (line_model == idle_lvl) send_toggle();
    send_tick();
    send_tick();
    send_request();
    send_tick();  // restore and start land on this tick
    play_out(0);
    // a zero timeout never matches after the increment
    set_registers(1'b0, 16'd0, 16'd0);
    if (line_model == idle_lvl) send_toggle();
    idle_ticks(20, 0);
  endtask

  task automatic test_table_end();
    set_registers(1'b1, 16'd40, 16'd3);
    for (int unsigned i = 0; i < DEPTH; i++) send_item(MODE_WRITE, 6'(i), 16'(i / 2 + 1));
    frame_len = DEPTH;
    send_request();
    play_out(0);
    idle_ticks(50, 5);
  endtask

  // Second-pass threshold crosses 16 bits; a truncated sum would fire at once.
  task automatic test_threshold_carry();
    set_registers(line_model, 16'hFFFF, 16'hFFF0);
    send_item(MODE_WRITE, 6'd0, 16'h0020);
    send_item(MODE_WRITE, 6'd1, 16'd0);
    frame_len = 1;
    send_request();
    no_gaps = 1'b1;
    while (!second_pass || tick_cnt < 32'd60) send_tick();
    // zeroing the waiting entry closes the second pass
    send_item(MODE_WRITE, 6'd0, 16'd0);
    frame_len = 0;
    play_out(0);
    no_gaps = 1'b0;
    idle_ticks(10, 30);
  endtask

  task automatic test_output_backpressure();
    set_registers(1'b1, 16'd30, 16'd5);
    load_frame(4, 3);
    send_request();
    hold_ticket <= hold_ticket + 1;
    repeat (80) begin
      if ($urandom_range(0, 3) == 0) send_noise(1'b0);
      else send_tick();
    end
    play_out(3);
  endtask

  task automatic test_random_frames(int unsigned budget);
    int unsigned first;
    int unsigned frames;
    logic [15:0] tmo;
    first  = items_sent;
    frames = 0;
    while (items_sent - first < budget) begin
      if (frames % 4 == 0) begin
        case ($urandom_range(0, 5))
          0:       tmo = 16'd0;
          1:       tmo = 16'hFFFF;
          default: tmo = 16'($urandom_range(1, 120));
        endcase
        set_registers(1'($urandom), tmo,
                      ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 20)));
      end
      if ($urandom_range(0, 9) == 0) load_frame(DEPTH, 1);
      else load_frame($urandom_range(0, 6), 5);
      idle_ticks($urandom_range(0, 30), 15);
      send_request();
      if ($urandom_range(0, 5) == 0) begin
        send_tick();
        send_request();
      end
      play_out(5);
      idle_ticks($urandom_range(0, 60), 10);
      frames++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_table_fill();
    test_reset_timeout();
    test_empty_frame();
    test_short_frame();
    test_timeout_then_start();
    test_table_end();
    test_threshold_carry();
    test_output_backpressure();
    test_random_frames(150);
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("requests: %0d (%0d ticks, %0d writes, %0d send requests, %0d manual toggles)",
             items_sent, mode_count[MODE_TICK], mode_count[MODE_WRITE],
             mode_count[MODE_SEND], mode_count[MODE_TOGGLE]);
    $display("frames started: %0d, idle restores: %0d, beats checked: %0d, mismatches: %0d",
             frames_started, idle_restores, beats_checked, err_count);
    if (err_count == 0 && status_due_q.size() == 0) begin
      $display("timed_toggle_pulse_player_core test passed");
    end else begin
      $display("timed_toggle_pulse_player_core test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ttpp_pkg.sv
rtl/ttpp_table.sv
rtl/timed_toggle_pulse_player_core.sv
verif/tb_top.sv
